// File: src/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, inactive during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, inactive during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gdp_pkg.sv
// ----------------------------------------------------------------------------
// gdp_pkg
// Shared constants and types of the group delay block.
// ----------------------------------------------------------------------------
package gdp_pkg;

  localparam int DELAY_WIDTH = 48;

  // round(2^44 / (2*pi)), unsigned Q44
  localparam int INV_TWO_PI_WIDTH = 42;
  localparam logic [INV_TWO_PI_WIDTH-1:0] INV_TWO_PI_Q44 = 42'd2799883368761;

  // quotient bits dropped to reach 2^-40 s per lsb
  localparam int QUOT_SHIFT = 24;

  typedef logic signed [DELAY_WIDTH-1:0] delay_t;

  localparam delay_t DELAY_MAX = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
  localparam delay_t DELAY_MIN = {1'b1, {(DELAY_WIDTH-1){1'b0}}};

endpackage

// File: src/gdp_point_if.sv
// ----------------------------------------------------------------------------
// gdp_point_if
// Sweep point channel: phase, frequency and end-of-sweep flag.
// ----------------------------------------------------------------------------
interface gdp_point_if #(
  parameter int PHASE_WIDTH = 32,
  parameter int FREQ_WIDTH  = 40
);
  logic                          valid;
  logic                          ready;
  logic signed [PHASE_WIDTH-1:0] phase;
  logic [FREQ_WIDTH-1:0]         freq;
  logic                          last_point;

  modport source (output valid, output phase, output freq, output last_point, input ready);
  modport sink   (input valid, input phase, input freq, input last_point, output ready);
endinterface

// File: src/gdp_delay_if.sv
// ----------------------------------------------------------------------------
// gdp_delay_if
// Group delay result channel.
// ----------------------------------------------------------------------------
interface gdp_delay_if import gdp_pkg::*;;
  logic   valid;
  logic   ready;
  delay_t delay;
  logic   last_result;

  modport source (output valid, output delay, output last_result, input ready);
  modport sink   (input valid, input delay, input last_result, output ready);
endinterface

// File: src/gdp_slope_unit.sv
// ----------------------------------------------------------------------------
// gdp_slope_unit
// Serial slope engine: shift-add multiply of |dphi| by 1/(2*pi), then a
// restoring divide by |df|, one bit per cycle, then sign and saturation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdp_slope_unit import gdp_pkg::*; #(
  parameter int PHASE_WIDTH = 32,
  parameter int FREQ_WIDTH  = 40
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [PHASE_WIDTH:0] dphi,
  input  logic signed [FREQ_WIDTH:0]  dfreq,
  output logic                        done,
  output delay_t                      delay
);

  localparam int AW  = PHASE_WIDTH + 1;
  localparam int KW  = INV_TWO_PI_WIDTH;
  localparam int PRW = KW + AW;
  localparam int NHW = PRW - QUOT_SHIFT;
  localparam int QXW = (NHW > DELAY_WIDTH) ? NHW : DELAY_WIDTH;
  localparam int CW  = $clog2(NHW + 1);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;
  localparam logic [1:0] M_DONE = 2'd3;

  logic [1:0]            ustate;
  logic [CW-1:0]         cnt;
  logic                  neg;
  logic [FREQ_WIDTH-1:0] adf;
  logic [PRW-1:0]        prod;
  logic [FREQ_WIDTH-1:0] rem;
  logic [NHW-1:0]        quo;

  logic [AW-1:0]         aphi;
  logic [FREQ_WIDTH-1:0] adf_in;
  logic                  phi_pos, phi_neg, df_pos, df_neg;
  logic [KW:0]           msum;
  logic [PRW-1:0]        prod_next;
  logic [FREQ_WIDTH:0]   dtrial;
  logic [FREQ_WIDTH+1:0] ddiff;
  logic                  take;
  logic [FREQ_WIDTH-1:0] rem_next;
  logic [NHW-1:0]        quo_next;
  logic [QXW-1:0]        qx;
  logic                  over;
  delay_t                mag;

  assign phi_neg = dphi[AW-1];
  assign phi_pos = !dphi[AW-1] && (|dphi);
  assign df_neg  = dfreq[FREQ_WIDTH];
  assign df_pos  = !dfreq[FREQ_WIDTH] && (|dfreq);
  assign aphi    = phi_neg ? AW'(-dphi) : AW'(dphi);
  assign adf_in  = df_neg ? FREQ_WIDTH'(-dfreq) : FREQ_WIDTH'(dfreq);

  // multiplier bits consumed lsb first, partial sum shifted right
  assign msum      = {1'b0, prod[PRW-1:AW]} + (prod[0] ? {1'b0, INV_TWO_PI_Q44} : '0);
  assign prod_next = {msum, prod[AW-1:1]};

  assign dtrial   = {rem, quo[NHW-1]};
  assign ddiff    = {1'b0, dtrial} - {2'b00, adf};
  assign take     = !ddiff[FREQ_WIDTH+1];
  assign rem_next = take ? ddiff[FREQ_WIDTH-1:0] : dtrial[FREQ_WIDTH-1:0];
  assign quo_next = {quo[NHW-2:0], take};

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= M_IDLE;
      cnt    <= '0;
    end else begin
      unique case (ustate)
        M_IDLE: begin
          if (start) begin
            ustate <= M_MUL;
            cnt    <= '0;
          end
        end
        M_MUL: begin
          if (cnt == CW'(AW - 1)) begin
            ustate <= M_DIV;
            cnt    <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        M_DIV: begin
          if (cnt == CW'(NHW - 1)) begin
            ustate <= M_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        M_DONE: ustate <= M_IDLE;
        default: ustate <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ustate == M_IDLE && start) begin
      neg  <= (phi_pos && df_pos) || (phi_neg && df_neg);
      adf  <= adf_in;
      prod <= {{KW{1'b0}}, aphi};
    end
    if (ustate == M_MUL) begin
      prod <= prod_next;
      if (cnt == CW'(AW - 1)) begin
        // low quotient bits never reach the output, drop them from the dividend
        quo <= prod_next[PRW-1:QUOT_SHIFT];
        rem <= '0;
      end
    end
    if (ustate == M_DIV) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign qx   = QXW'(quo);
  assign over = |qx[QXW-1:DELAY_WIDTH-1];
  assign mag  = {1'b0, qx[DELAY_WIDTH-2:0]};

  always_comb begin
    if (neg) begin
      delay = over ? DELAY_MIN : -mag;
    end else begin
      delay = over ? DELAY_MAX : mag;
    end
  end

  assign done = (ustate == M_DONE);

  `ASSERT_IMPL(a_start_when_idle, clk, rst, start, ustate == M_IDLE, "start while busy")
  `ASSERT_NEXT(a_done_then_idle, clk, rst, done, ustate == M_IDLE && !done, "done not one pulse")

endmodule

// File: src/group_delay_from_phase_core.sv
// flow: a point that completes a difference gives its word after the calc state, the wait on
//   the slope unit (skipped when df is zero) and the put state, which loads the output word
// pacing: no new point is taken until that word is loaded, which needs the result side to keep up;
//   a word with nonzero df comes from one serial slope pass of multiply and divide; a last point
//   after others gives two words from two passes, and a first point is only stored
// reset: synchronous active-high rst empties the point history and the output word
// ----------------------------------------------------------------------------
// group_delay_from_phase_core
// Group delay -(dphi/df)/(2*pi) over a streamed sweep, central differences
// inside the sweep and one-sided differences at its ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module group_delay_from_phase_core import gdp_pkg::*; #(
  parameter int PHASE_WIDTH = 32,
  parameter int FREQ_WIDTH  = 40
) (
  input  logic        clk,
  input  logic        rst,
  gdp_point_if.sink   point,
  gdp_delay_if.source result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_PUT  = 2'd3;

  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_FIRST = 2'd1;
  localparam logic [1:0] HELD_INNER = 2'd2;

  logic [1:0]                    state;
  logic [1:0]                    held;
  logic signed [PHASE_WIDTH-1:0] older_phase, newer_phase;
  logic [FREQ_WIDTH-1:0]         older_freq, newer_freq;

  logic signed [PHASE_WIDTH:0]   cur_dphi, b_dphi;
  logic signed [FREQ_WIDTH:0]    cur_dfreq, b_dfreq;
  logic                          cur_last, second;
  delay_t                        pend_delay;
  logic                          pend_last;

  logic                          out_valid;
  delay_t                        out_delay;
  logic                          out_last;

  logic signed [PHASE_WIDTH-1:0] in_phase;
  logic [FREQ_WIDTH-1:0]         in_freq;
  logic                          accept;
  logic signed [PHASE_WIDTH:0]   dphi_a, dphi_b;
  logic signed [FREQ_WIDTH:0]    dfreq_a, dfreq_b;
  logic                          u_start, u_done;
  delay_t                        u_delay;
  logic                          load_out;

  assign in_phase    = point.phase;
  assign in_freq     = point.freq;
  assign point.ready = (state == S_IDLE);
  assign accept      = point.valid && point.ready;

  assign dphi_b  = {in_phase[PHASE_WIDTH-1], in_phase}
                 - {newer_phase[PHASE_WIDTH-1], newer_phase};
  assign dfreq_b = {1'b0, in_freq} - {1'b0, newer_freq};
  assign dphi_a  = (held == HELD_INNER) ?
                   {in_phase[PHASE_WIDTH-1], in_phase}
                   - {older_phase[PHASE_WIDTH-1], older_phase} : dphi_b;
  assign dfreq_a = (held == HELD_INNER) ? {1'b0, in_freq} - {1'b0, older_freq} : dfreq_b;

  assign u_start  = (state == S_CALC) && (|cur_dfreq);
  assign load_out = (state == S_PUT) && (!out_valid || result.ready);

  gdp_slope_unit #(
    .PHASE_WIDTH (PHASE_WIDTH),
    .FREQ_WIDTH  (FREQ_WIDTH)
  ) u_slope (
    .clk   (clk),
    .rst   (rst),
    .start (u_start),
    .dphi  (cur_dphi),
    .dfreq (cur_dfreq),
    .done  (u_done),
    .delay (u_delay)
  );

  // sequencer and point history
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      held   <= HELD_NONE;
      second <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (point.last_point) begin
              held <= HELD_NONE;
            end else if (held != HELD_NONE) begin
              held <= HELD_INNER;
            end else begin
              held <= HELD_FIRST;
            end
            if (held != HELD_NONE) begin
              state  <= S_CALC;
              second <= point.last_point;
            end else if (point.last_point) begin
              // single-point sweep
              state  <= S_PUT;
              second <= 1'b0;
            end
          end
        end
        S_CALC: state <= (|cur_dfreq) ? S_WAIT : S_PUT;
        S_WAIT: begin
          if (u_done) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (load_out) begin
            state  <= second ? S_CALC : S_IDLE;
            second <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!point.last_point) begin
        older_phase <= newer_phase;
        older_freq  <= newer_freq;
        newer_phase <= in_phase;
        newer_freq  <= in_freq;
      end
      cur_dphi   <= dphi_a;
      cur_dfreq  <= dfreq_a;
      cur_last   <= 1'b0;
      b_dphi     <= dphi_b;
      b_dfreq    <= dfreq_b;
      pend_delay <= '0;
      pend_last  <= 1'b1;
    end
    if (state == S_CALC) begin
      pend_delay <= '0;
      pend_last  <= cur_last;
    end
    if (state == S_WAIT && u_done) begin
      pend_delay <= u_delay;
    end
    if (load_out && second) begin
      cur_dphi  <= b_dphi;
      cur_dfreq <= b_dfreq;
      cur_last  <= 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_delay <= pend_delay;
      out_last  <= pend_last;
    end
  end

  assign result.valid       = out_valid;
  assign result.delay       = out_delay;
  assign result.last_result = out_last;

  `ASSERT_IMPL(a_start_in_calc, clk, rst, u_start, state == S_CALC, "slope start outside calc")
  `ASSERT_NEXT(a_done_to_put, clk, rst, state == S_WAIT && u_done, state == S_PUT,
               "slope result not forwarded")
  `ASSERT_NEXT(a_last_word_frees, clk, rst, load_out && pend_last, state == S_IDLE && held == HELD_NONE,
               "sweep end did not return to idle")

endmodule
